@@ sv/stree_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the segment tree range reducer.
// No dependencies; stree_alu and the top level import this package.
package stree_pkg;

  // Tree geometry
  localparam int unsigned LEAVES    = 1024;
  localparam int unsigned LEAF_BASE = 2 ** $clog2(LEAVES);
  localparam int unsigned NODES     = 2 * LEAF_BASE;
  localparam int unsigned NODE_AW   = $clog2(NODES);
  localparam int unsigned POS_W     = NODE_AW + 1;

  // Field widths
  localparam int unsigned DATA_W = 64;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned MODE_W = 2;

  // Reduction select
  localparam logic [OP_W-1:0] OP_MIN = 2'd0;
  localparam logic [OP_W-1:0] OP_MAX = 2'd1;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_OP_KIND      = 1'b0;
  localparam logic CFG_ARRAY_LENGTH = 1'b1;

  localparam logic signed [DATA_W-1:0] MIN_IDENTITY = 64'sh4000_0000_0000_0000;
  localparam logic signed [DATA_W-1:0] MAX_IDENTITY = 64'shC000_0000_0000_0000;
  localparam logic [LEN_W-1:0]         LEN_RESET    = 11'd1024;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         index_left;
    logic [LEN_W-1:0]         index_right;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     bad_index;
  } out_item_t;

  function automatic logic signed [DATA_W-1:0] identity(input logic [OP_W-1:0] op);
    logic signed [DATA_W-1:0] id;
    if (op == OP_MIN) id = MIN_IDENTITY;
    else if (op == OP_MAX) id = MAX_IDENTITY;
    else id = '0;
    return id;
  endfunction

endpackage

@@ sv/stree_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stree_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/stree_alu.sv @@
`timescale 1ns / 1ps
// Shared reduction unit: signed min, signed max or wrapping sum of two nodes.
// Depends on stree_pkg.
module stree_alu (
  input  logic [stree_pkg::OP_W-1:0]          op_i,
  input  logic signed [stree_pkg::DATA_W-1:0] a_i,
  input  logic signed [stree_pkg::DATA_W-1:0] b_i,
  output logic signed [stree_pkg::DATA_W-1:0] res_o
);
  import stree_pkg::*;

  logic b_lt_a;

  assign b_lt_a = (b_i < a_i);

  always_comb begin
    // select code 3 behaves as sum
    if (op_i == OP_MIN) begin
      res_o = b_lt_a ? b_i : a_i;
    end else if (op_i == OP_MAX) begin
      res_o = (a_i < b_i) ? b_i : a_i;
    end else begin
      res_o = a_i + b_i;
    end
  end

endmodule

@@ sv/segment_tree_range_reduce_unit.sv @@
`timescale 1ns / 1ps
// Segment tree range reducer: top level with sequencer, node RAM and reduce unit.
// Depends on stree_pkg, stree_ram and stree_alu.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one transaction (update, read,
//   range query or fill); output channel out_valid_o / out_stall_i returns one
//   result per transaction. A transaction moves when valid is high and stall low.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 op_kind,
//   1 array_length); write only while the block is idle.
//   One transaction is worked at a time; in_stall_o is high while busy.
//   Steps from accept to result register (node RAM has one read port,
//   one registered read per step, and the reduce unit is shared):
//     bad index    : nothing is computed
//     point update : leaf write, then one parent write per tree level, 10 levels
//     point read   : the leaf is read, then its registered data is the result
//     range query  : per tree level, fold the low end if odd, then the high end
//     fill         : 1024 leaf writes, then per inner node read left, read right, write
//   After reset the node RAM is swept to the min identity, all 2048 nodes, with
//   in_stall_o high. The output register holds a result while out_stall_i is
//   high; a new transaction is still accepted, and the block waits only when
//   the next result is ready and the previous one has not yet been taken.
module segment_tree_range_reduce_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  stree_pkg::in_item_t         in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output stree_pkg::out_item_t        out_item_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [stree_pkg::LEN_W-1:0] cfg_data_i
);
  import stree_pkg::*;

  typedef enum logic [13:0] {
    ST_CLEAR    = 14'b00000000000001,
    ST_IDLE     = 14'b00000000000010,
    ST_U_LEAF   = 14'b00000000000100,
    ST_U_LVL    = 14'b00000000001000,
    ST_R_RD     = 14'b00000000010000,
    ST_R_WAIT   = 14'b00000000100000,
    ST_Q_LO     = 14'b00000001000000,
    ST_Q_LO_ACC = 14'b00000010000000,
    ST_Q_HI     = 14'b00000100000000,
    ST_Q_HI_ACC = 14'b00001000000000,
    ST_F_LEAF   = 14'b00010000000000,
    ST_F_RL     = 14'b00100000000000,
    ST_F_RR     = 14'b01000000000000,
    ST_F_W      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  logic [OP_W-1:0]  op_kind_q, op_kind_d;
  logic [LEN_W-1:0] array_length_q, array_length_d;

  logic [NODE_AW-1:0]       k_q, k_d;
  logic [POS_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic signed [DATA_W-1:0] acc_q, acc_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] res_q, res_d;
  logic                     bad_q, bad_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic                     ram_we;
  logic [NODE_AW-1:0]       ram_waddr, ram_raddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rdata_s;

  logic signed [DATA_W-1:0] alu_a, alu_b, alu_res;

  logic [LEN_W-1:0]   len;
  logic               in_fire, out_free;
  logic [NODE_AW-1:0] parent, k_dbl;
  logic [POS_W-1:0]   hi_dec, fill_end;

  stree_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  stree_alu u_alu (
    .op_i (op_kind_q),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .res_o(alu_res)
  );

  assign rdata_s  = ram_rdata;
  assign len      = (array_length_q > LEN_W'(LEAVES)) ? LEN_W'(LEAVES) : array_length_q;
  assign in_stall_o = (state_q != ST_IDLE) || done_q;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign parent   = k_q >> 1;
  assign k_dbl    = NODE_AW'({k_q, 1'b0});
  assign hi_dec   = hi_q - POS_W'(1);
  assign fill_end = POS_W'(LEAF_BASE) + POS_W'(len);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // config registers
  always_comb begin
    op_kind_d      = op_kind_q;
    array_length_d = array_length_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OP_KIND:      op_kind_d = cfg_data_i[OP_W-1:0];
        CFG_ARRAY_LENGTH: array_length_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    done_d    = done_q;
    k_d       = k_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    val_d     = val_q;
    res_d     = res_q;
    bad_d     = bad_q;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = alu_res;
    ram_raddr = k_q;
    alu_a     = acc_q;
    alu_b     = rdata_s;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = MIN_IDENTITY;
        k_d       = k_q + NODE_AW'(1);
        if (k_q == NODE_AW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          val_d = in_item_i.value;
          res_d = '0;
          bad_d = 1'b0;
          k_d   = NODE_AW'(LEAF_BASE) + NODE_AW'(in_item_i.index_left);
          lo_d  = POS_W'(LEAF_BASE) + POS_W'(in_item_i.index_left);
          hi_d  = POS_W'(LEAF_BASE) + POS_W'(in_item_i.index_right);
          acc_d = identity(op_kind_q);
          unique case (in_item_i.mode)
            MODE_UPDATE, MODE_READ: begin
              if (LEN_W'(in_item_i.index_left) >= len) begin
                bad_d  = 1'b1;
                done_d = 1'b1;
              end else if (in_item_i.mode == MODE_UPDATE) begin
                state_d = ST_U_LEAF;
              end else begin
                state_d = ST_R_RD;
              end
            end
            MODE_QUERY: begin
              if (in_item_i.index_right > len || LEN_W'(in_item_i.index_left) > len) begin
                bad_d  = 1'b1;
                done_d = 1'b1;
              end else begin
                state_d = ST_Q_LO;
              end
            end
            default: begin
              k_d     = NODE_AW'(LEAF_BASE);
              state_d = ST_F_LEAF;
            end
          endcase
        end
      end
      ST_U_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = val_q;
        ram_raddr = k_q ^ NODE_AW'(1);
        acc_d     = val_q;
        state_d   = ST_U_LVL;
      end
      ST_U_LVL: begin
        // rdata is the sibling of k; keep left/right order
        alu_a     = k_q[0] ? rdata_s : acc_q;
        alu_b     = k_q[0] ? acc_q : rdata_s;
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_raddr = parent ^ NODE_AW'(1);
        acc_d     = alu_res;
        k_d       = parent;
        if (parent == NODE_AW'(1)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      ST_R_RD: begin
        state_d = ST_R_WAIT;
      end
      ST_R_WAIT: begin
        res_d   = rdata_s;
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      ST_Q_LO: begin
        ram_raddr = lo_q[NODE_AW-1:0];
        if (lo_q >= hi_q) begin
          res_d   = acc_q;
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else if (lo_q[0]) begin
          state_d = ST_Q_LO_ACC;
        end else begin
          state_d = ST_Q_HI;
        end
      end
      ST_Q_LO_ACC: begin
        acc_d   = alu_res;
        lo_d    = lo_q + POS_W'(1);
        state_d = ST_Q_HI;
      end
      ST_Q_HI: begin
        ram_raddr = hi_dec[NODE_AW-1:0];
        if (hi_q[0]) begin
          hi_d    = hi_dec;
          state_d = ST_Q_HI_ACC;
        end else begin
          lo_d    = lo_q >> 1;
          hi_d    = hi_q >> 1;
          state_d = ST_Q_LO;
        end
      end
      ST_Q_HI_ACC: begin
        acc_d   = alu_res;
        lo_d    = lo_q >> 1;
        hi_d    = hi_q >> 1;
        state_d = ST_Q_LO;
      end
      ST_F_LEAF: begin
        // leaves past the length get the current identity
        ram_we    = 1'b1;
        ram_wdata = (POS_W'(k_q) < fill_end) ? val_q : identity(op_kind_q);
        k_d       = k_q + NODE_AW'(1);
        if (k_q == NODE_AW'(NODES - 1)) begin
          k_d     = NODE_AW'(LEAF_BASE - 1);
          state_d = ST_F_RL;
        end
      end
      ST_F_RL: begin
        ram_raddr = k_dbl;
        state_d   = ST_F_RR;
      end
      ST_F_RR: begin
        ram_raddr = k_dbl | NODE_AW'(1);
        acc_d     = rdata_s;
        state_d   = ST_F_W;
      end
      ST_F_W: begin
        ram_we = 1'b1;
        k_d    = k_q - NODE_AW'(1);
        if (k_q == NODE_AW'(1)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = ST_F_RL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hand the finished result to the output register
    if (state_q == ST_IDLE && done_q && out_free) begin
      done_d = 1'b0;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_IDLE && done_q && out_free) begin
      out_valid_d             = 1'b1;
      out_item_d.result_value = res_q;
      out_item_d.bad_index    = bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      done_q         <= 1'b0;
      k_q            <= '0;
      op_kind_q      <= OP_MIN;
      array_length_q <= LEN_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      done_q         <= done_d;
      k_q            <= k_d;
      op_kind_q      <= op_kind_d;
      array_length_q <= array_length_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    acc_q      <= acc_d;
    val_q      <= val_d;
    res_q      <= res_d;
    bad_q      <= bad_d;
    out_item_q <= out_item_d;
  end

endmodule
